@@ rtl/assert_macros.svh @@
// assertion helper macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wear_pkg.sv @@
// ----------------------------------------------------------------------------
// wear_pkg
// shared constants, register codes and types of the energy activity detector
// ----------------------------------------------------------------------------
package wear_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int INDEX_BITS  = 32;
	localparam int WINDOW_BITS = 16;

	localparam int MAG_W   = SAMPLE_BITS + 1;
	localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W   = SQ_W + WINDOW_BITS;
	localparam int CNT_W   = WINDOW_BITS + 1;
	localparam int THR_W   = 31;
	localparam int WLEN_W  = 16;
	localparam int MARGIN_W = 24;
	localparam int PROD_W  = THR_W + CNT_W;
	localparam int OUT_W   = 32;

	// alignment of the Q1.30 threshold against the squared-sample scale
	localparam int SUM_SHL = (2 * SAMPLE_BITS < 32) ? 32 - 2 * SAMPLE_BITS : 0;
	localparam int THR_SHL = (2 * SAMPLE_BITS > 32) ? 2 * SAMPLE_BITS - 32 : 0;
	localparam int CMP_W   = (SUM_W + SUM_SHL > PROD_W + THR_SHL) ?
		SUM_W + SUM_SHL : PROD_W + THR_SHL;

	localparam int ADD_W   = ((INDEX_BITS > MARGIN_W) ? INDEX_BITS : MARGIN_W) + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 2'd2;

	localparam logic [THR_W-1:0]    THR_RESET    = 31'd1073741;
	localparam logic [WLEN_W-1:0]   WLEN_RESET   = 16'd480;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 24'd0;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [THR_W-1:0]    threshold;
		logic [WLEN_W-1:0]   window_len;
		logic [MARGIN_W-1:0] margin;
	} cfg_t;

	typedef struct packed {
		logic [SQ_W-1:0] sq;
		logic            last;
	} sq_item_t;

	typedef struct packed {
		logic [SUM_W-1:0]      sum;
		logic [CNT_W-1:0]      cnt;
		logic [INDEX_BITS-1:0] wstart;
		logic [INDEX_BITS-1:0] wend;
		logic                  last;
	} win_rec_t;

endpackage

@@ rtl/windowed_energy_activity_region_core.sv @@
// ----------------------------------------------------------------------------
// windowed_energy_activity_region_core
// energy based voice activity region detector over a sample stream
// ----------------------------------------------------------------------------
// usage:
// - input channel in_valid/in_ready carries one signed sample and a last flag
//   per request; one sample can be taken every cycle while the queue has room
// - the stream is cut into windows of window_length samples; a window is
//   active when its summed energy exceeds energy_threshold times its count
// - on the request with last set, one result request goes out on
//   out_valid/out_ready: activity flag plus region start and exclusive end
// - path of the last sample to its result: queue, accumulate, threshold product,
//   activity update, output register
// - throughput: one sample per cycle, set by the single accumulate stage
// - a result waiting on a stalled receiver holds the whole window engine;
//   the 4-entry queue keeps absorbing samples, then in_ready drops
// - config port cfg_valid/cfg_ready/cfg_index/cfg_data is always ready;
//   write it only while the block is idle
// - reset: registers return to their defaults, the stream state is cleared,
//   the queue is emptied
// ----------------------------------------------------------------------------
module windowed_energy_activity_region_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [wear_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                    last,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    speech_flag,
	output logic [wear_pkg::OUT_W-1:0]              span_begin,
	output logic [wear_pkg::OUT_W-1:0]              span_end,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [wear_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [wear_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import wear_pkg::*;

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_not_empty;
	sq_item_t q_wr_item;
	sq_item_t q_rd_item;

	// register file, writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THR_RESET;
			cfg_q.window_len <= WLEN_RESET;
			cfg_q.margin     <= MARGIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold  <= cfg_data[THR_W-1:0];
				REG_WINDOW:    cfg_q.window_len <= cfg_data[WLEN_W-1:0];
				REG_MARGIN:    cfg_q.margin     <= cfg_data[MARGIN_W-1:0];
				default:       cfg_q            <= cfg_q;
			endcase
		end
	end

	// front: take samples, square them
	wear_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.last     (last),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_wr_item)
	);

	// decoupling queue
	wear_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_item   (q_wr_item),
		.pop       (q_pop),
		.rd_item   (q_rd_item),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// back: window engine and result register
	wear_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item         (q_rd_item),
		.item_valid   (q_not_empty),
		.item_pop     (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.speech_flag  (speech_flag),
		.span_begin   (span_begin),
		.span_end     (span_end)
	);

endmodule

@@ rtl/wear_front.sv @@
// ----------------------------------------------------------------------------
// wear_front
// input side: takes samples and pushes their squared magnitude into the queue
// ----------------------------------------------------------------------------
module wear_front (
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [wear_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                  last,
	input  logic                                  q_full,
	output logic                                  q_push,
	output wear_pkg::sq_item_t                    q_item
);
	import wear_pkg::*;

	logic [MAG_W-1:0]   mag;
	logic [2*MAG_W-1:0] sq_full;

	// magnitude, the most negative code gives full scale
	assign mag = sample[SAMPLE_BITS-1] ? (MAG_W'(0) - {sample[SAMPLE_BITS-1], sample})
		: {1'b0, sample};
	assign sq_full = mag * mag;

	assign in_ready    = !q_full;
	assign q_push      = in_valid && !q_full;
	assign q_item.sq   = sq_full[SQ_W-1:0];
	assign q_item.last = last;

endmodule

@@ rtl/wear_fifo.sv @@
// ----------------------------------------------------------------------------
// wear_fifo
// short register queue between the input side and the window engine
// ----------------------------------------------------------------------------
module wear_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wear_pkg::sq_item_t wr_item,
	input  logic               pop,
	output wear_pkg::sq_item_t rd_item,
	output logic               full,
	output logic               not_empty
);
	import wear_pkg::*;

	sq_item_t              ent_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign full      = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/wear_back.sv @@
// ----------------------------------------------------------------------------
// wear_back
// window engine: accumulate, threshold product, activity tracking, result
// ----------------------------------------------------------------------------
module wear_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wear_pkg::cfg_t                  cfg,
	input  wear_pkg::sq_item_t              item,
	input  logic                            item_valid,
	output logic                            item_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            speech_flag,
	output logic [wear_pkg::OUT_W-1:0]      span_begin,
	output logic [wear_pkg::OUT_W-1:0]      span_end
);
	import wear_pkg::*;

	logic                   en;

	// accumulate stage state
	logic [SUM_W-1:0]       sum_q;
	logic [WINDOW_BITS-1:0] fill_q;
	logic [INDEX_BITS-1:0]  idx_q;
	logic [INDEX_BITS-1:0]  wstart_q;

	logic [WINDOW_BITS-1:0] len_w;
	logic [WINDOW_BITS-1:0] len_eff;
	logic [SUM_W-1:0]       sum_n;
	logic [WINDOW_BITS-1:0] fill_n;
	logic [INDEX_BITS-1:0]  idx_n;
	logic                   close;

	win_rec_t               rec_s1;
	logic                   rec_vld_s1;
	win_rec_t               rec_s2;
	logic [PROD_W-1:0]      prod_s2;
	logic                   rec_vld_s2;

	// activity tracking state
	logic                   found_q;
	logic [INDEX_BITS-1:0]  first_q;
	logic [INDEX_BITS-1:0]  lastact_q;

	logic [CMP_W-1:0]       cmp_lhs;
	logic [CMP_W-1:0]       cmp_rhs;
	logic                   active;
	logic                   found_n;
	logic [INDEX_BITS-1:0]  first_n;
	logic [INDEX_BITS-1:0]  lastact_n;

	logic                   res_vld_s3;
	logic                   res_found_s3;
	logic [INDEX_BITS-1:0]  res_first_s3;
	logic [INDEX_BITS-1:0]  res_last_s3;
	logic [INDEX_BITS-1:0]  res_idx_s3;

	logic [ADD_W-1:0]       margin_x;
	logic [ADD_W-1:0]       first_x;
	logic [ADD_W-1:0]       idx_x;
	logic [ADD_W-1:0]       end_sum;
	logic [ADD_W-1:0]       start_v;
	logic [ADD_W-1:0]       end_v;
	logic                   has_v;

	logic                   out_valid_q;
	logic                   has_q;
	logic [OUT_W-1:0]       start_q;
	logic [OUT_W-1:0]       end_q;

	// whole engine holds while a result waits
	assign en       = !out_valid_q || out_ready;
	assign item_pop = en && item_valid;

	assign len_w   = WINDOW_BITS'(cfg.window_len);
	assign len_eff = (len_w == '0) ? WINDOW_BITS'(1) : len_w;
	assign sum_n   = sum_q + SUM_W'(item.sq);
	assign fill_n  = fill_q + WINDOW_BITS'(1);
	assign idx_n   = idx_q + INDEX_BITS'(1);
	assign close   = (fill_n >= len_eff) || (fill_n == '0) || item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			fill_q     <= '0;
			idx_q      <= '0;
			wstart_q   <= '0;
			rec_vld_s1 <= 1'b0;
		end else if (en) begin
			rec_vld_s1 <= item_valid && close;
			if (item_valid) begin
				if (close) begin
					sum_q  <= '0;
					fill_q <= '0;
				end else begin
					sum_q  <= sum_n;
					fill_q <= fill_n;
				end
				if (item.last) begin
					idx_q    <= '0;
					wstart_q <= '0;
				end else begin
					idx_q <= idx_n;
					if (close) begin
						wstart_q <= idx_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && item_valid && close) begin
			rec_s1.sum    <= sum_n;
			rec_s1.cnt    <= {fill_n == '0, fill_n};
			rec_s1.wstart <= wstart_q;
			rec_s1.wend   <= idx_n;
			rec_s1.last   <= item.last;
		end
	end

	// threshold times sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_s2 <= 1'b0;
		end else if (en) begin
			rec_vld_s2 <= rec_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && rec_vld_s1) begin
			rec_s2  <= rec_s1;
			prod_s2 <= PROD_W'(cfg.threshold) * PROD_W'(rec_s1.cnt);
		end
	end

	assign cmp_lhs   = CMP_W'(rec_s2.sum) << SUM_SHL;
	assign cmp_rhs   = CMP_W'(prod_s2) << THR_SHL;
	assign active    = cmp_lhs > cmp_rhs;
	assign found_n   = found_q || active;
	assign first_n   = (active && !found_q) ? rec_s2.wstart : first_q;
	assign lastact_n = active ? rec_s2.wend : lastact_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			first_q    <= '1;
			lastact_q  <= '0;
			res_vld_s3 <= 1'b0;
		end else if (en) begin
			res_vld_s3 <= rec_vld_s2 && rec_s2.last;
			if (rec_vld_s2) begin
				if (rec_s2.last) begin
					found_q   <= 1'b0;
					first_q   <= '1;
					lastact_q <= '0;
				end else begin
					found_q   <= found_n;
					first_q   <= first_n;
					lastact_q <= lastact_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && rec_vld_s2 && rec_s2.last) begin
			res_found_s3 <= found_n;
			res_first_s3 <= first_n;
			res_last_s3  <= lastact_n;
			res_idx_s3   <= rec_s2.wend;
		end
	end

	// widen by the margin, floor at zero, cap at stream length
	assign margin_x = ADD_W'(cfg.margin);
	assign first_x  = ADD_W'(res_first_s3);
	assign idx_x    = ADD_W'(res_idx_s3);
	assign end_sum  = ADD_W'(res_last_s3) + margin_x;
	assign has_v    = res_found_s3 && (res_first_s3 < res_last_s3);
	assign start_v  = (first_x > margin_x) ? (first_x - margin_x) : '0;
	assign end_v    = (end_sum > idx_x) ? idx_x : end_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_vld_s3) begin
			has_q   <= has_v;
			start_q <= has_v ? OUT_W'(start_v) : '0;
			end_q   <= has_v ? OUT_W'(end_v) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign speech_flag = has_q;
	assign span_begin  = start_q;
	assign span_end    = end_q;

endmodule

@@ rtl/wear_checker.sv @@
// ----------------------------------------------------------------------------
// wear_checker
// port-level checks on the result channel of the activity detector
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wear_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         speech_flag,
	input logic [wear_pkg::OUT_W-1:0]   span_begin,
	input logic [wear_pkg::OUT_W-1:0]   span_end
);
	import wear_pkg::*;

	logic span_zero;
	logic span_ordered;

	assign span_zero    = (span_begin == '0) && (span_end == '0);
	assign span_ordered = span_begin < span_end;

	// a pending result stays up
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")

	// no activity means an empty region
	`ASSERT_IMPL(a_idle_zero, clk, arst_n, out_valid && !speech_flag, span_zero, "empty region")

	// an active region is never empty
	`ASSERT_IMPL(a_region_order, clk, arst_n, out_valid && speech_flag, span_ordered, "bad order")

endmodule

bind windowed_energy_activity_region_core wear_checker u_wear_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.speech_flag  (speech_flag),
	.span_begin   (span_begin),
	.span_end     (span_end)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for windowed_energy_activity_region_core: sample
// buffers of loud and quiet stretches go in under random idling and
// back-pressure, and each buffer's activity region is predicted bit for bit
// and compared field by field with the block's result
// ----------------------------------------------------------------------------

import wear_pkg::*;

typedef struct packed {
	logic                 active;
	logic [OUT_W-1:0]     lo;
	logic [OUT_W-1:0]     hi;
} region_t;

class activity_region_tracker;
	localparam int ALIGN = 2 * SAMPLE_BITS - 32;
	localparam bit [63:0] IDX_MASK = (64'd1 << INDEX_BITS) - 64'd1;
	localparam bit [63:0] WIN_MASK = (64'd1 << WINDOW_BITS) - 64'd1;

	bit [63:0] threshold, window_len, margin;
	bit [63:0] energy, fill, index, seg_origin, first_hit, last_hit;
	bit        any_hit;
	region_t   expected_regions[$];
	int        errors, regions_seen, active_seen;

	function new();
		threshold  = 64'(THR_RESET);
		window_len = 64'(WLEN_RESET);
		margin     = 64'(MARGIN_RESET);
		clear_buffer();
	endfunction

	function void clear_buffer();
		energy     = 0;
		fill       = 0;
		index      = 0;
		seg_origin = 0;
		first_hit  = IDX_MASK;
		last_hit   = 0;
		any_hit    = 0;
	endfunction

	function void note_setting(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] data);
		case (reg_index)
			REG_THRESHOLD: threshold = 64'(data[THR_W-1:0]);
			REG_WINDOW: window_len = 64'(data[WLEN_W-1:0]);
			REG_MARGIN: margin = 64'(data[MARGIN_W-1:0]);
			default: ;
		endcase
	endfunction

	// one accepted sample: accumulate, close the window if due, emit at buffer end
	function void take_sample(logic [SAMPLE_BITS-1:0] value, logic is_last);
		bit [63:0] raw, mag, len, count, lhs, rhs, hi, lo_full;
		region_t   r;
		raw = 0;
		raw[SAMPLE_BITS-1:0] = value;
		mag = raw[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - raw : raw;
		len = window_len & WIN_MASK;
		if (len == 0)
			len = 1;
		energy = energy + mag * mag;
		fill   = (fill + 1) & WIN_MASK;
		index  = (index + 1) & IDX_MASK;
		if (fill >= len || fill == 0 || is_last) begin
			count = (fill == 0) ? WIN_MASK + 1 : fill;
			lhs   = energy;
			rhs   = threshold * count;
			if (ALIGN > 0)
				rhs = rhs << ALIGN;
			else if (ALIGN < 0)
				lhs = lhs << (-ALIGN);
			if (lhs > rhs) begin
				if (!any_hit)
					first_hit = seg_origin;
				any_hit  = 1;
				last_hit = index;
			end
			seg_origin = index;
			energy     = 0;
			fill       = 0;
		end
		if (!is_last)
			return;
		r = '0;
		if (any_hit && first_hit < last_hit) begin
			r.active = 1'b1;
			lo_full  = (first_hit > margin) ? first_hit - margin : 64'd0;
			r.lo     = lo_full[OUT_W-1:0];
			hi       = last_hit + margin;
			if (hi > index)
				hi = index;
			r.hi = hi[OUT_W-1:0];
		end
		expected_regions.push_back(r);
		clear_buffer();
	endfunction

	function void check_region(logic act, logic [OUT_W-1:0] lo, logic [OUT_W-1:0] hi);
		region_t want;
		if (expected_regions.size() == 0) begin
			$error("result with no buffer end waiting: speech_flag=%0d span_begin=%0d span_end=%0d",
				act, lo, hi);
			errors++;
			return;
		end
		want = expected_regions.pop_front();
		regions_seen++;
		if (want.active)
			active_seen++;
		if (act !== want.active) begin
			$error("speech_flag: expected %0d, actual %0d", want.active, act);
			errors++;
		end
		if (lo !== want.lo) begin
			$error("span_begin: expected %0d, actual %0d", want.lo, lo);
			errors++;
		end
		if (hi !== want.hi) begin
			$error("span_end: expected %0d, actual %0d", want.hi, hi);
			errors++;
		end
	endfunction

	function int pending();
		return expected_regions.size();
	endfunction
endclass

module testbench;

	// spare register index, not decoded by the block
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int TARGET_ITEMS   = 2000;
	localparam int CALM_ITEMS     = 200;
	localparam int SETTLE         = 20;    // covers the result path plus queue
	localparam int HOLD_OFF       = 300;   // long receiver stall
	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request moving

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample    = '0;
	logic                          last      = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          speech_flag;
	logic [OUT_W-1:0]              span_begin;
	logic [OUT_W-1:0]              span_end;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data  = '0;

	activity_region_tracker tracker;

	// handshakes between the two processes
	bit calm;           // last stretch of the run: no idling anywhere
	bit hold_off_req;   // asks the receiver for one long stall

	int samples_sent, buffers_sent, settings_written, long_holds;
	int quiet_cycles;

	windowed_energy_activity_region_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.speech_flag (speech_flag),
		.span_begin  (span_begin),
		.span_end    (span_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// observe every request on all three channels, values as they were before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.note_setting(cfg_index, cfg_data);
			if (in_valid && in_ready)
				tracker.take_sample(sample, last);
			if (out_valid && out_ready)
				tracker.check_region(speech_flag, span_begin, span_end);
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// receiver: random ready bursts, one long hold-off on request, always ready when calm
	initial begin
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				hold_off_req = 1'b0;
				long_holds++;
				repeat (HOLD_OFF) @(posedge clk);
			end else if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// one register write request; valid is left high for a following write
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// full register set, block must be idle; optionally a write to the spare index
	task automatic apply_settings(input logic [31:0] thr, input logic [31:0] win,
			input logic [31:0] mrg, input bit spare);
		put_reg(REG_THRESHOLD, thr);
		put_reg(REG_WINDOW, win);
		put_reg(REG_MARGIN, mrg);
		if (spare)
			put_reg(REG_SPARE, $urandom());
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	task automatic send_item(input logic [SAMPLE_BITS-1:0] value, input logic is_last);
		in_valid <= 1'b1;
		sample   <= value;
		last     <= is_last;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
		if (is_last)
			buffers_sent++;
	endtask

	task automatic pause_sender(input int gap_pct);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// sender stops until every expected result is in, then lets the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one buffer of loud and quiet stretches, sometimes pure noise
	task automatic send_buffer(input int length, input int quiet_amp, input int loud_amp,
			input int gap_pct);
		int i, seg_left, v;
		bit loud, noise;
		noise = ($urandom_range(0, 7) == 0);
		seg_left = 0;
		loud = 0;
		for (i = 0; i < length; i++) begin
			if (seg_left == 0) begin
				loud = ($urandom_range(0, 2) == 0);
				seg_left = $urandom_range(1, 12);
			end
			seg_left--;
			if (noise)
				v = int'($urandom_range(0, 65535)) - 32768;
			else if ($urandom_range(0, 31) == 0)
				v = $urandom_range(0, 1) ? 32767 : -32768;
			else begin
				v = $urandom_range(0, loud ? loud_amp : quiet_amp);
				if ($urandom_range(0, 1))
					v = -v;
				if (v > 32767)
					v = 32767;
			end
			pause_sender(gap_pct);
			send_item(16'(v), i == length - 1);
		end
	endtask

	// extremes, zero and maximum window, partial windows, a window shortened mid-way
	task automatic run_directed();
		// threshold zero, one-sample windows: any nonzero sample is active
		apply_settings(32'd0, 32'd1, 32'd0, 1'b0);
		send_item(16'sd0, 1'b1);
		send_item(-16'sd32768, 1'b0);
		send_item(16'sd32767, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sd1, 1'b1);
		drain();
		// window zero acts as one, junk in upper data bits, full margin clamps at both ends
		apply_settings(32'h3FFF_FFFF, 32'hABCD_0000, 32'h00FF_FFFF, 1'b1);
		send_item(16'sd0, 1'b0);
		send_item(-16'sd32768, 1'b0);
		send_item(16'sd5, 1'b1);
		drain();
		// top threshold: nothing can pass
		apply_settings(32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0);
		send_item(-16'sd32768, 1'b1);
		drain();
		// longest window, buffer ends inside it: partial count is used
		apply_settings(32'd1000, 32'd65535, 32'd2, 1'b0);
		send_item(16'sd100, 1'b0);
		send_item(-16'sd200, 1'b0);
		send_item(16'sd300, 1'b1);
		drain();
		// window shortened while one is open: it closes at the next sample
		apply_settings(32'd0, 32'd8, 32'd1, 1'b0);
		repeat (4) send_item(16'sd0, 1'b0);
		send_item(16'sd7, 1'b0);
		drain();
		apply_settings(32'd0, 32'd3, 32'd1, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sd0, 1'b1);
		drain();
	endtask

	task automatic run_random();
		int phase_no, n_buf, b, gap_pct, quiet_amp, loud_amp, lvl;
		logic [31:0] thr, win, mrg;
		phase_no = 0;
		while (samples_sent < TARGET_ITEMS) begin
			calm = (samples_sent >= TARGET_ITEMS - CALM_ITEMS);
			quiet_amp = $urandom_range(0, 300);
			loud_amp  = $urandom_range(1000, 32768);
			case ($urandom_range(0, 7))
				0: thr = 32'd0;
				1: thr = 32'h4000_0000;
				2: thr = 32'hFFFF_FFFF;
				3: thr = $urandom();
				default: begin
					lvl = $urandom_range(quiet_amp, loud_amp);
					thr = 32'((longint'(lvl) * lvl) / 3);
				end
			endcase
			case ($urandom_range(0, 9))
				0: win = 32'd0;
				1: win = 32'd65535;
				2: win = $urandom_range(17, 300);
				default: win = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 7))
				0: mrg = 32'd0;
				1: mrg = 32'h00FF_FFFF;
				2: mrg = $urandom_range(0, 24'hFF_FFFF);
				default: mrg = $urandom_range(0, 20);
			endcase
			// junk above the register width must be dropped
			if ($urandom_range(0, 1))
				win[31:16] = 16'($urandom());
			if ($urandom_range(0, 1))
				mrg[31:24] = 8'($urandom());
			apply_settings(thr, win, mrg, $urandom_range(0, 9) == 0);
			if (calm)
				gap_pct = 0;
			else
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 40;
				endcase
			if (phase_no == 3) begin
				// short buffers back to back while the receiver holds off: queue fills up
				hold_off_req = 1'b1;
				for (b = 0; b < 40; b++)
					send_buffer($urandom_range(1, 3), quiet_amp, loud_amp, 0);
			end else begin
				n_buf = $urandom_range(2, 6);
				for (b = 0; b < n_buf; b++) begin
					if (!calm && $urandom_range(0, 9) == 0)
						drain();
					send_buffer($urandom_range(1, 80), quiet_amp, loud_amp, gap_pct);
				end
			end
			drain();
			phase_no++;
		end
	endtask

	initial begin
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		drain();
		$display("ran %0d samples in %0d buffers over %0d register settings",
			samples_sent, buffers_sent, settings_written);
		$display("checked %0d regions, %0d with activity, %0d long receiver hold-offs",
			tracker.regions_seen, tracker.active_seen, long_holds);
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
